>>> hw/rtl/qwu_pkg.sv
`default_nettype none

package qwu_pkg;

    // field widths
    localparam int DATA_W  = 32;
    localparam int DIV_W   = 31;
    localparam int HALF_W  = DIV_W - 1;
    localparam int IDX_W   = 2;

    // divider steps, one quotient bit each
    localparam int DIV_STEPS = DATA_W;

    // register indexes
    localparam logic [IDX_W-1:0] REG_WEIGHT_DIVIDER = 2'd0;
    localparam logic [IDX_W-1:0] REG_BIAS_DIVIDER   = 2'd1;

    // commands
    localparam logic CMD_WEIGHT = 1'b0;
    localparam logic CMD_BIAS   = 1'b1;

    // int8 clip bounds, sized for the wide difference
    localparam logic signed [DATA_W+1:0] WEIGHT_MAX = 34'sd127;
    localparam logic signed [DATA_W+1:0] WEIGHT_MIN = -34'sd128;

    // input transaction as registered
    typedef struct packed {
        logic                     cmd;
        logic signed [DATA_W-1:0] param;
        logic signed [DATA_W-1:0] grad;
    } in_item_t;

    // payload carried through the divider stages
    typedef struct packed {
        logic                     cmd;
        logic                     neg;
        logic signed [DATA_W-1:0] param;
        logic [DIV_W-1:0]         div;
        logic [HALF_W-1:0]        half;
        logic [DIV_W-1:0]         rem;
        logic [DATA_W-1:0]        quo;
    } stage_t;

endpackage

`default_nettype wire

>>> hw/rtl/quantized_weight_update_top.sv
`default_nettype none

// channel  | transaction             | fields
// ---------+-------------------------+--------------------------------------------
// s_axis   | parameter update in     | tuser: command; tdata: param_value, grad_in
// m_axis   | updated parameter out   | tdata: new_value, grad_residual
// cfg      | divider register write  | cfg_index, cfg_data (no read-back)
//
// one transaction accepted per cycle while m_axis does not stall; input to output
// register passes input stage, dividend prep, 32 radix-2 divider stages, result stage;
// the 32-step restoring divider sets the latency, each stage one subtract/compare
// reset clears the divider registers to 1 and all stage valid bits
// a stall at m_axis freezes the whole pipeline; s_tready follows it

module quantized_weight_update_top
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // [31:0] param_value, [63:32] grad_in
    input  wire logic [0:0]  s_tuser,   // [0] command

    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [63:0] m_tdata,   // [31:0] new_value, [63:32] grad_residual

    input  wire logic                         cfg_we,
    input  wire logic [qwu_pkg::IDX_W-1:0]    cfg_index,
    input  wire logic [qwu_pkg::DIV_W-1:0]    cfg_data
);

    localparam int W = qwu_pkg::DATA_W;
    localparam int N = qwu_pkg::DIV_STEPS;

    // configuration registers
    logic [qwu_pkg::DIV_W-1:0] weight_div_reg;
    logic [qwu_pkg::DIV_W-1:0] bias_div_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_div_reg <= qwu_pkg::DIV_W'(1);
            bias_div_reg   <= qwu_pkg::DIV_W'(1);
        end
        else if (cfg_we)
        begin
            if (cfg_index == qwu_pkg::REG_WEIGHT_DIVIDER)
                weight_div_reg <= cfg_data;
            else if (cfg_index == qwu_pkg::REG_BIAS_DIVIDER)
                bias_div_reg <= cfg_data;
        end
    end

    // pipeline advance
    logic en;
    logic out_valid_reg;

    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    // input stage
    logic               in_valid_reg;
    qwu_pkg::in_item_t  in_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (en)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            in_reg.cmd   <= s_tuser[0];
            in_reg.param <= s_tdata[W-1:0];
            in_reg.grad  <= s_tdata[2*W-1:W];
        end
    end

    // dividend prep: n = grad + floor(div/2), split into sign and magnitude
    logic [qwu_pkg::DIV_W-1:0]  sel_div;
    logic [qwu_pkg::DIV_W-1:0]  eff_div;
    logic [qwu_pkg::HALF_W-1:0] half;
    logic signed [W:0]          dividend;
    logic [W:0]                 dividend_abs;
    qwu_pkg::stage_t            prep;

    always_comb
    begin
        sel_div      = (in_reg.cmd == qwu_pkg::CMD_BIAS) ? bias_div_reg : weight_div_reg;
        eff_div      = (sel_div == '0) ? qwu_pkg::DIV_W'(1) : sel_div;
        half         = eff_div[qwu_pkg::DIV_W-1:1];
        dividend     = {in_reg.grad[W-1], in_reg.grad}
                       + $signed({3'b000, half});
        dividend_abs = dividend[W] ? (~dividend + (W+1)'(1)) : dividend;
        prep.cmd     = in_reg.cmd;
        prep.neg     = dividend[W];
        prep.param   = in_reg.param;
        prep.div     = eff_div;
        prep.half    = half;
        prep.rem     = '0;
        prep.quo     = dividend_abs[W-1:0];
    end

    // divider stages: stage k holds the item after k quotient bits
    logic [N:0]      stg_valid_reg;
    qwu_pkg::stage_t stg_reg [0:N];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stg_valid_reg[0] <= 1'b0;
        else if (en)
            stg_valid_reg[0] <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            stg_reg[0] <= prep;
    end

    genvar k;
    generate
        for (k = 0; k < N; k++)
        begin : g_div
            logic [qwu_pkg::DIV_W:0] trial;
            logic [qwu_pkg::DIV_W:0] diff;
            qwu_pkg::stage_t         step_next;

            // one restoring step: shift in the next dividend bit, try to subtract
            always_comb
            begin
                step_next = stg_reg[k];
                trial     = {stg_reg[k].rem, stg_reg[k].quo[W-1]};
                diff      = trial - {1'b0, stg_reg[k].div};
                if (trial >= {1'b0, stg_reg[k].div})
                begin
                    step_next.rem = diff[qwu_pkg::DIV_W-1:0];
                    step_next.quo = {stg_reg[k].quo[W-2:0], 1'b1};
                end
                else
                begin
                    step_next.rem = trial[qwu_pkg::DIV_W-1:0];
                    step_next.quo = {stg_reg[k].quo[W-2:0], 1'b0};
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    stg_valid_reg[k+1] <= 1'b0;
                else if (en)
                    stg_valid_reg[k+1] <= stg_valid_reg[k];
            end

            always_ff @(posedge clk)
            begin
                if (en)
                    stg_reg[k+1] <= step_next;
            end
        end
    endgenerate

    // result stage: signed quotient, residual = signed remainder - floor(div/2)
    qwu_pkg::stage_t          fin;
    logic signed [W+1:0]      q_signed;
    logic signed [W+1:0]      nv_wide;
    logic signed [W-1:0]      rem_signed;
    logic signed [W-1:0]      new_value_next;
    logic signed [W-1:0]      residual_next;

    always_comb
    begin
        fin        = stg_reg[N];
        q_signed   = fin.neg ? -$signed({2'b00, fin.quo}) : $signed({2'b00, fin.quo});
        nv_wide    = {{2{fin.param[W-1]}}, fin.param} - q_signed;
        rem_signed = fin.neg ? -$signed({1'b0, fin.rem}) : $signed({1'b0, fin.rem});
        residual_next = rem_signed - $signed({2'b00, fin.half});
        if (fin.cmd == qwu_pkg::CMD_WEIGHT)
        begin
            if (nv_wide > qwu_pkg::WEIGHT_MAX)
                new_value_next = W'(qwu_pkg::WEIGHT_MAX);
            else if (nv_wide < qwu_pkg::WEIGHT_MIN)
                new_value_next = W'(qwu_pkg::WEIGHT_MIN);
            else
                new_value_next = nv_wide[W-1:0];
        end
        else
        begin
            new_value_next = nv_wide[W-1:0];
        end
    end

    // output register
    logic [W-1:0] new_value_reg;
    logic [W-1:0] residual_reg;
    logic         out_cmd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= stg_valid_reg[N];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            new_value_reg <= new_value_next;
            residual_reg  <= residual_next;
            out_cmd_reg   <= fin.cmd;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {residual_reg, new_value_reg};

    // weight results always land in int8 range
    a_weight_clip: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_cmd_reg == qwu_pkg::CMD_WEIGHT)
        |-> ($signed(new_value_reg) <= 32'sd127 && $signed(new_value_reg) >= -32'sd128))
        else $error("weight result outside int8 range");

    // divider remainder stays below the divisor at the last stage
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stg_valid_reg[N] |-> (stg_reg[N].rem < stg_reg[N].div))
        else $error("divider remainder not below divisor");

    // a frozen pipeline keeps its output valid
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |=> out_valid_reg)
        else $error("result dropped during stall");

    // an accepted transaction enters the input stage
    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> in_valid_reg)
        else $error("accepted transaction lost at input stage");

endmodule

`default_nettype wire
